// ===== hdl/gtr_pkg.sv =====
package gtr_pkg;

  localparam int unsigned GLYPH_ROWS   = 7;
  localparam int unsigned GLYPH_COLS   = 5;
  localparam int unsigned GLYPH_PIX    = GLYPH_ROWS * GLYPH_COLS;
  localparam int unsigned COL_W        = $clog2(GLYPH_COLS);
  localparam int unsigned STEP_W       = 2;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam logic [15:0] COLOR_RESET  = 16'hFFFF;
  localparam logic [7:0]  SCALE_RESET  = 8'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEXT_COLOR  = 1'b0,
    REG_GLYPH_SCALE = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OP_ACCEPT  = 2'd0,
    OP_SETUP   = 2'd1,
    OP_SCAN    = 2'd2,
    OP_ADVANCE = 2'd3
  } uop_e;

  typedef enum logic [1:0] {
    COND_ALWAYS    = 2'd0,
    COND_NO_INPUT  = 2'd1,
    COND_EMPTY     = 2'd2,
    COND_SCAN_HOLD = 2'd3
  } ucond_e;

  typedef struct packed {
    uop_e              op;
    ucond_e            cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic empty;
    logic scan_hold;
  } seq_stat_t;

  // Each step jumps to its target when the condition holds, else falls through.
  function automatic ucode_t gtr_ucode(input logic [STEP_W-1:0] step);
    ucode_t w;
    unique case (step)
      2'd0: w = '{op: OP_ACCEPT,  cond: COND_NO_INPUT,  target: 2'd0};
      2'd1: w = '{op: OP_SETUP,   cond: COND_EMPTY,     target: 2'd3};
      2'd2: w = '{op: OP_SCAN,    cond: COND_SCAN_HOLD, target: 2'd2};
      2'd3: w = '{op: OP_ADVANCE, cond: COND_ALWAYS,    target: 2'd0};
    endcase
    return w;
  endfunction

  // Rows top first, each row with the leftmost column in its high bit.
  // Unknown codes and the space have no lit pixels.
  function automatic logic [GLYPH_PIX-1:0] gtr_font(input logic [7:0] code);
    logic [GLYPH_PIX-1:0] b;
    unique case (code)
      8'h2D: b = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
      8'h41: b = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      8'h42: b = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      8'h43: b = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
      8'h44: b = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
      8'h45: b = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      8'h46: b = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      8'h47: b = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
      8'h48: b = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      8'h49: b = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
      8'h4A: b = {5'h07, 5'h02, 5'h02, 5'h02, 5'h02, 5'h12, 5'h0C};
      8'h4B: b = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      8'h4C: b = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      8'h4D: b = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
      8'h4E: b = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
      8'h4F: b = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      8'h50: b = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      8'h51: b = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
      8'h52: b = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
      8'h53: b = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      8'h54: b = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      8'h55: b = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      8'h56: b = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
      8'h57: b = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
      8'h58: b = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
      8'h59: b = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
      8'h5A: b = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
      8'h62: b = {5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h11, 5'h1E};
      8'h6F: b = {5'h00, 5'h00, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E};
      8'h74: b = {5'h08, 5'h08, 5'h1F, 5'h08, 5'h08, 5'h08, 5'h06};
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/gtr_useq.sv =====
module gtr_useq (
  input  logic                clk,
  input  logic                rst_n,
  input  gtr_pkg::seq_stat_t  stat,
  output gtr_pkg::uop_e       op
);
  import gtr_pkg::*;

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  ucode_t            uw;
  logic              take;

  always_comb begin
    uw = gtr_ucode(step_r);
    unique case (uw.cond)
      COND_ALWAYS:    take = 1'b1;
      COND_NO_INPUT:  take = !stat.in_valid;
      COND_EMPTY:     take = stat.empty;
      COND_SCAN_HOLD: take = stat.scan_hold;
    endcase
    step_nxt = take ? uw.target : step_r + 1'b1;
    op       = uw.op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== hdl/glyph_text_rasterizer.sv =====
// Channel  Direction  Payload                                          Handshake
// in_      input      char_code, starts_string, start_x, row_y        in_valid / in_ready
// out_     output     square_x, square_y, square_size, square_color,  out_valid / out_ready
//                     last_square
// cfg_     input      index 0 text_color, index 1 glyph_scale         cfg_we
//
// A character passes through accept, font lookup setup, a scan of at most 35 pixels and the
// cursor advance; the scan stops after the last lit pixel. An empty glyph or a zero scale
// skips the scan.
// The scan issues at most one square per cycle from a single output register.
// A stalled output register holds the scan when it reaches a lit pixel, until the word is taken.
// Reset is synchronous and active low; it clears the cursor and loads the register defaults.
module glyph_text_rasterizer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_char_code,
  input  logic                               in_starts_string,
  input  logic signed [15:0]                 in_start_x,
  input  logic signed [15:0]                 in_row_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [15:0]                 out_square_x,
  output logic signed [15:0]                 out_square_y,
  output logic [7:0]                         out_square_size,
  output logic [15:0]                        out_square_color,
  output logic                               out_last_square,
  input  logic                               cfg_we,
  input  logic [gtr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gtr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import gtr_pkg::*;

  uop_e                 op;
  seq_stat_t            stat;
  logic [15:0]          text_color_r;
  logic [7:0]           glyph_scale_r;
  logic [15:0]          cursor_r;
  logic [15:0]          x_r;
  logic [15:0]          y_r;
  logic [COL_W-1:0]     col_r;
  logic [GLYPH_PIX-1:0] pix_r;
  logic                 out_valid_r;
  logic [15:0]          out_x_r;
  logic [15:0]          out_y_r;
  logic [7:0]           out_size_r;
  logic [15:0]          out_color_r;
  logic                 out_last_r;
  logic [15:0]          scale16;
  logic                 emit;
  logic                 stall;
  logic                 more;

  gtr_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .op    (op)
  );

  always_comb begin
    scale16        = {8'd0, glyph_scale_r};
    emit           = (op == OP_SCAN) && pix_r[GLYPH_PIX-1];
    stall          = emit && out_valid_r && !out_ready;
    more           = |pix_r[GLYPH_PIX-2:0];
    stat.in_valid  = in_valid;
    stat.empty     = (glyph_scale_r == 8'd0) || (pix_r == '0);
    stat.scan_hold = stall || more;
    in_ready       = (op == OP_ACCEPT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r  <= COLOR_RESET;
      glyph_scale_r <= SCALE_RESET;
      cursor_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_e'(cfg_index))
          REG_TEXT_COLOR:  text_color_r  <= cfg_wdata[15:0];
          REG_GLYPH_SCALE: glyph_scale_r <= cfg_wdata[7:0];
        endcase
      end

      if (emit && !stall) begin
        out_valid_r <= 1'b1;
        out_x_r     <= x_r;
        out_y_r     <= y_r;
        out_size_r  <= glyph_scale_r;
        out_color_r <= text_color_r;
        out_last_r  <= !more;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (op)
        OP_ACCEPT: begin
          if (in_valid) begin
            if (in_starts_string) begin
              cursor_r <= in_start_x;
            end
            pix_r <= gtr_font(in_char_code);
            y_r   <= in_row_y;
          end
        end
        OP_SETUP: begin
          x_r   <= cursor_r;
          col_r <= '0;
        end
        OP_SCAN: begin
          if (!stall) begin
            pix_r <= {pix_r[GLYPH_PIX-2:0], 1'b0};
            if (col_r == COL_W'(GLYPH_COLS - 1)) begin
              col_r <= '0;
              x_r   <= cursor_r;
              y_r   <= y_r + scale16;
            end else begin
              col_r <= col_r + 1'b1;
              x_r   <= x_r + scale16;
            end
          end
        end
        OP_ADVANCE: begin
          cursor_r <= cursor_r + {scale16[13:0], 2'b00} + {scale16[14:0], 1'b0};
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_square_x     = out_x_r;
  assign out_square_y     = out_y_r;
  assign out_square_size  = out_size_r;
  assign out_square_color = out_color_r;
  assign out_last_square  = out_last_r;

endmodule
